/* sv/stp_pkg.sv */
// Shared types and constants for the software timer pool.
package stp_pkg;

  localparam int HANDLE_W       = 8;
  localparam int TICK_W         = 32;
  localparam int CMD_W          = 3;
  localparam int DEF_NUM_TIMERS = 16;

  localparam logic [HANDLE_W-1:0] NO_HANDLE = 8'hFF;

  typedef enum logic [CMD_W-1:0] {
    CMD_CREATE   = 3'd0,
    CMD_START    = 3'd1,
    CMD_STOP     = 3'd2,
    CMD_STOP_ALL = 3'd3,
    CMD_EXPIRED  = 3'd4,
    CMD_ELAPSED  = 3'd5
  } cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic                create;
    logic                en_set;
    logic                en_clr;
    logic                clr_all;
    logic                mode;
    logic [HANDLE_W-1:0] handle;
  } flag_op_t;

endpackage

/* sv/stp_ram.sv */
// Generic single-port-write, registered-read RAM.
module stp_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/stp_flags.sv */
// Allocation counter and per-timer enable and mode flags.
module stp_flags import stp_pkg::*; #(
  parameter  int NUM_TIMERS = DEF_NUM_TIMERS,
  localparam int CNT_W      = $clog2(NUM_TIMERS + 1),
  localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  flag_op_t              op,
  output logic [CNT_W-1:0]      count,
  output logic [NUM_TIMERS-1:0] en_vec,
  output logic [NUM_TIMERS-1:0] mode_vec
);

  logic [IDX_W-1:0] cidx;
  logic [IDX_W-1:0] hidx;

  assign cidx = count[IDX_W-1:0];
  assign hidx = op.handle[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      en_vec   <= '0;
      mode_vec <= '0;
    end else begin
      if (op.clr_all) begin
        en_vec <= '0;
      end
      if (op.create) begin
        mode_vec[cidx] <= op.mode;
        en_vec[cidx]   <= 1'b0;
        count          <= count + CNT_W'(1);
      end
      if (op.en_set) begin
        en_vec[hidx] <= 1'b1;
      end
      if (op.en_clr) begin
        en_vec[hidx] <= 1'b0;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(NUM_TIMERS))
    else $error("allocation count beyond bank size");

  a_unalloc_off: assert property (@(posedge clk) disable iff (rst)
    (en_vec >> count) == '0)
    else $error("unallocated timer enabled");

endmodule

/* sv/software_timer_pool.sv */
// Software timer pool top level: request decode, timer memories and response register.
//
// A bank of NUM_TIMERS timers. Each request transaction on the req channel
// (req_valid/req_stall) carries cmd, handle, mode, period_ms and now_tick;
// each produces exactly one response transaction on the rsp channel
// (rsp_valid/rsp_stall) with new_handle, expired and elapsed_ms.
// A request accepted while idle reads the start-tick and period memories at
// the accepting edge; the entry is updated and the response registered once
// the execute state finds the response register free, raising rsp_valid.
// The memory read comes before the write-back, so a new request is not
// accepted until the last one has executed; only one request executes at a time.
// While the receiver stalls with a response held, a new request can still
// be accepted and its memory read done; it then waits for the register.
// Reset empties the bank (no handles allocated) and disables every timer;
// the timer memories need no clearing as an entry's contents are used only once it
// has been started.
module software_timer_pool import stp_pkg::*; #(
  parameter int NUM_TIMERS = DEF_NUM_TIMERS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  logic [CMD_W-1:0]    cmd,
  input  logic [HANDLE_W-1:0] handle,
  input  logic                mode,
  input  logic [TICK_W-1:0]   period_ms,
  input  logic [TICK_W-1:0]   now_tick,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output logic [HANDLE_W-1:0] new_handle,
  output logic                expired,
  output logic [TICK_W-1:0]   elapsed_ms
);

  localparam int CNT_W = $clog2(NUM_TIMERS + 1);
  localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  state_t state, state_next;
  logic   exec_fire;

  cmd_t                req_cmd;
  logic [HANDLE_W-1:0] req_handle;
  logic                req_mode;
  logic [TICK_W-1:0]   req_period;
  logic [TICK_W-1:0]   req_now;

  logic [CNT_W-1:0]      count;
  logic [NUM_TIMERS-1:0] en_vec;
  logic [NUM_TIMERS-1:0] mode_vec;
  flag_op_t              op;

  logic [IDX_W-1:0]  raddr;
  logic [IDX_W-1:0]  idx;
  logic [TICK_W-1:0] start_rd;
  logic [TICK_W-1:0] period_rd;
  logic              st_we;
  logic              pd_we;
  logic [TICK_W-1:0] st_wdata;

  logic              alloc;
  logic              hit;
  logic [TICK_W-1:0] diff;
  logic              due;
  logic [HANDLE_W-1:0] nh;
  logic                exp_bit;
  logic [TICK_W-1:0]   el;
  flag_op_t            op_raw;
  logic                st_we_raw;
  logic                pd_we_raw;

  // control
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (req_valid) state_next = ST_EXEC;
      ST_EXEC: if (!rsp_valid || !rsp_stall) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req_stall = (state != ST_IDLE);
    exec_fire = (state == ST_EXEC) && (!rsp_valid || !rsp_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      req_cmd    <= cmd_t'(cmd);
      req_handle <= handle;
      req_mode   <= mode;
      req_period <= period_ms;
      req_now    <= now_tick;
    end
  end

  // timer memories
  assign raddr = (state == ST_IDLE) ? handle[IDX_W-1:0] : req_handle[IDX_W-1:0];
  assign idx   = req_handle[IDX_W-1:0];

  stp_ram #(.WIDTH(TICK_W), .DEPTH(NUM_TIMERS), .ADDR_W(IDX_W)) u_start_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (idx),
    .wdata (st_wdata),
    .raddr (raddr),
    .rdata (start_rd)
  );

  stp_ram #(.WIDTH(TICK_W), .DEPTH(NUM_TIMERS), .ADDR_W(IDX_W)) u_period_ram (
    .clk   (clk),
    .we    (pd_we),
    .waddr (idx),
    .wdata (req_period),
    .raddr (raddr),
    .rdata (period_rd)
  );

  stp_flags #(.NUM_TIMERS(NUM_TIMERS)) u_flags (
    .clk      (clk),
    .rst      (rst),
    .op       (op),
    .count    (count),
    .en_vec   (en_vec),
    .mode_vec (mode_vec)
  );

  // execute
  assign alloc = req_handle < HANDLE_W'(count);
  assign hit   = alloc && en_vec[idx];
  assign diff  = req_now - start_rd;
  assign due   = diff >= period_rd;

  always_comb begin
    nh        = NO_HANDLE;
    exp_bit   = 1'b0;
    el        = '0;
    op_raw    = '0;
    st_we_raw = 1'b0;
    pd_we_raw = 1'b0;
    st_wdata  = req_now;
    op_raw.mode   = req_mode;
    op_raw.handle = req_handle;
    unique case (req_cmd)
      CMD_CREATE: begin
        if (count < CNT_W'(NUM_TIMERS)) begin
          nh            = HANDLE_W'(count);
          op_raw.create = 1'b1;
        end
      end
      CMD_START: begin
        if (alloc) begin
          st_we_raw     = 1'b1;
          pd_we_raw     = 1'b1;
          op_raw.en_set = 1'b1;
        end
      end
      CMD_STOP: begin
        if (alloc) op_raw.en_clr = 1'b1;
      end
      CMD_STOP_ALL: begin
        op_raw.clr_all = 1'b1;
      end
      CMD_EXPIRED: begin
        if (hit && due) begin
          exp_bit = 1'b1;
          if (!mode_vec[idx]) begin
            op_raw.en_clr = 1'b1;
          end else begin
            st_we_raw = 1'b1;
            st_wdata  = start_rd + period_rd;
          end
        end
      end
      CMD_ELAPSED: begin
        if (hit) el = diff;
      end
      default: ;
    endcase
  end

  always_comb begin
    op = op_raw;
    op.create  = op_raw.create  && exec_fire;
    op.en_set  = op_raw.en_set  && exec_fire;
    op.en_clr  = op_raw.en_clr  && exec_fire;
    op.clr_all = op_raw.clr_all && exec_fire;
    st_we      = st_we_raw && exec_fire;
    pd_we      = pd_we_raw && exec_fire;
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (exec_fire) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      new_handle <= nh;
      expired    <= exp_bit;
      elapsed_ms <= el;
    end
  end

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> (state == ST_EXEC && req_stall))
    else $error("accepted request not taken into execute");

  a_rsp_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == ST_EXEC))
    else $error("response raised without an executing request");

  a_rsp_exclusive: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && expired) |-> (elapsed_ms == '0 && new_handle == NO_HANDLE))
    else $error("expired response carries other results");

endmodule
